>>> sv/fxalu_pkg.sv
// fxalu_pkg: action codes, widths and the per-stage token type of the
// q24.8 alu divider chain; no dependencies
package fxalu_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int WHOLE_W   = 24;
    localparam int NUM_W     = DATA_W + FRAC_BITS;   // dividend magnitude width
    localparam int DEN_W     = DATA_W + 1;           // divisor magnitude width
    localparam int MAG_W     = DATA_W + 1;           // magnitude of any operand
    localparam int STEPS     = NUM_W;                // one quotient bit per cell

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_MUL = 4'd2,
        ACT_DIV = 4'd3,
        ACT_MIN = 4'd4,
        ACT_MAX = 4'd5,
        ACT_INC = 4'd6,
        ACT_DEC = 4'd7,
        ACT_I2F = 4'd8
    } action_t;

    // item travelling down the cell row
    typedef struct packed {
        logic                    valid;
        logic                    is_div;     // quotient must be finished at the end
        logic                    neg;        // sign of the quotient
        logic [DEN_W-1:0]        den;        // divisor magnitude
        logic [NUM_W-1:0]        num;        // dividend bits, shifted out msb first
        logic [DEN_W:0]          rem;        // partial remainder
        logic [NUM_W-1:0]        quo;        // quotient bits, shifted in
        logic signed [DATA_W-1:0] res;       // result for non-divide actions
        logic                    ovf;
        logic                    dz;
        logic                    gt;
        logic                    lt;
        logic                    eq;
    } token_t;
endpackage

>>> sv/fxalu_front.sv
// fxalu_front: decodes one request, does add/sub/min/max/inc/dec/convert,
// the registered multiply and the divider set-up; uses fxalu_pkg
module fxalu_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [3:0]                       action,
    input  logic signed [fxalu_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fxalu_pkg::DATA_W-1:0] operand_b,
    output fxalu_pkg::token_t                tok_out
);
    import fxalu_pkg::*;

    // stage 1: registered decode and 32x32 multiply
    logic                        v1_reg;
    logic [3:0]                  act_reg;
    logic signed [DATA_W-1:0]    a_reg, b_reg;
    logic signed [2*DATA_W-1:0]  prod_reg;
    token_t                      tok_reg, tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            act_reg  <= action;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            prod_reg <= operand_a * operand_b;
        end
    end

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [DATA_W:0] sat64(input logic signed [2*DATA_W-1:0] v);
        logic [DATA_W:0] r;
        begin
            if (v > 64'sd2147483647)
                r = {1'b1, 32'h7FFF_FFFF};
            else if (v < -64'sd2147483648)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, v[DATA_W-1:0]};
            return r;
        end
    endfunction

    always_comb begin
        logic signed [2*DATA_W-1:0] ea, eb, sum, pm, rnd;
        logic [2*DATA_W-1:0]        pmag;
        logic [DATA_W:0]            s;
        logic [MAG_W-1:0]           amag, bmag;
        ea   = 64'(a_reg);
        eb   = 64'(b_reg);
        sum  = '0;
        s    = '0;
        pm   = prod_reg;
        pmag = pm[2*DATA_W-1] ? 64'(-pm) : 64'(pm);
        pmag = (pmag + 64'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
        rnd  = pm[2*DATA_W-1] ? -$signed(pmag) : $signed(pmag);
        amag = a_reg[DATA_W-1] ? MAG_W'(-ea) : MAG_W'(ea);
        bmag = b_reg[DATA_W-1] ? MAG_W'(-eb) : MAG_W'(eb);

        tok_next        = '0;
        tok_next.valid  = v1_reg;
        tok_next.gt     = a_reg > b_reg;
        tok_next.lt     = a_reg < b_reg;
        tok_next.eq     = a_reg == b_reg;
        tok_next.neg    = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        tok_next.den    = DEN_W'(bmag);
        tok_next.num    = NUM_W'(amag) << FRAC_BITS;
        case (act_reg)
            ACT_ADD: begin sum = ea + eb; s = sat64(sum); end
            ACT_SUB: begin sum = ea - eb; s = sat64(sum); end
            ACT_MUL: s = sat64(rnd);
            ACT_DIV: begin
                if (b_reg == '0) begin
                    s = {1'b0, a_reg};
                    tok_next.dz = 1'b1;
                end else begin
                    tok_next.is_div = 1'b1;
                end
            end
            ACT_MIN: s = {1'b0, (a_reg <= b_reg) ? a_reg : b_reg};
            ACT_MAX: s = {1'b0, (a_reg >= b_reg) ? a_reg : b_reg};
            ACT_INC: begin sum = ea + 64'sd1; s = sat64(sum); end
            ACT_DEC: begin sum = ea - 64'sd1; s = sat64(sum); end
            ACT_I2F: begin sum = ea <<< FRAC_BITS; s = sat64(sum); end
            default: s = '0;
        endcase
        tok_next.res = s[DATA_W-1:0];
        tok_next.ovf = s[DATA_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (en) begin
            tok_reg.valid <= tok_next.valid;
        end
        if (en) begin
            tok_reg[$bits(token_t)-2:0] <= tok_next[$bits(token_t)-2:0];
        end
    end

    assign tok_out = tok_reg;
endmodule

>>> sv/fxalu_cell.sv
// fxalu_cell: one restoring-division step, one quotient bit per cycle
// while en is high, carrying the whole token to the next cell; uses fxalu_pkg
module fxalu_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  fxalu_pkg::token_t tok_in,
    output fxalu_pkg::token_t tok_out
);
    import fxalu_pkg::*;

    token_t tok_reg, tok_next;

    always_comb begin
        logic [DEN_W:0] trial;
        tok_next     = tok_in;
        trial        = {tok_in.rem[DEN_W-1:0], tok_in.num[NUM_W-1]};
        tok_next.num = {tok_in.num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, tok_in.den}) begin
            tok_next.rem = trial - {1'b0, tok_in.den};
            tok_next.quo = {tok_in.quo[NUM_W-2:0], 1'b1};
        end else begin
            tok_next.rem = trial;
            tok_next.quo = {tok_in.quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (en) begin
            tok_reg.valid <= tok_next.valid;
        end
        if (en) begin
            tok_reg[$bits(token_t)-2:0] <= tok_next[$bits(token_t)-2:0];
        end
    end

    assign tok_out = tok_reg;
endmodule

>>> sv/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: top level of the signed q24.8 alu
// depends on fxalu_pkg, fxalu_front and fxalu_cell
//
// usage:
//  - input channel s_valid/s_ready carries one request: s_action,
//    s_operand_a, s_operand_b; result channel m_valid/m_ready returns one
//    result per request, in request order
//  - every request passes a front stage (decode, registered multiply), a
//    set-up stage, then a row of 40 division cells (one quotient bit each)
//    and a finishing stage, for every action, divide or not
//  - throughput is one request per cycle unless the receiver stalls;
//    the whole row advances together
//  - when the receiver stalls with a result waiting, s_ready drops and the
//    whole row freezes in place, bubbles included, until m_ready returns
//  - reset (aresetn low, synchronous) empties the row and the output
//    register; no request is lost or duplicated afterwards
module fixed_point_q24_8_alu (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [3:0]                          s_action,
    input  logic signed [fxalu_pkg::DATA_W-1:0] s_operand_a,
    input  logic signed [fxalu_pkg::DATA_W-1:0] s_operand_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fxalu_pkg::DATA_W-1:0] m_result,
    output logic signed [fxalu_pkg::WHOLE_W-1:0] m_whole_part,
    output logic                                m_a_greater,
    output logic                                m_a_less,
    output logic                                m_a_equal,
    output logic                                m_divide_by_zero,
    output logic                                m_overflow
);
    import fxalu_pkg::*;

    // row advance: moves whenever the output register can take what leaves
    logic   adv;
    token_t chain [0:STEPS];
    token_t fin;

    logic                      out_v_reg;
    logic signed [DATA_W-1:0]  res_reg;
    logic signed [WHOLE_W-1:0] whole_reg;
    logic                      gt_reg, lt_reg, eq_reg, dz_reg, ovf_reg;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = adv;

    fxalu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .action    (s_action),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .tok_out   (chain[0])
    );

    // one cell per quotient bit
    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        fxalu_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign fin = chain[STEPS];

    // finish division: round half away from zero, sign, saturate
    logic signed [DATA_W-1:0]  res_next;
    logic                      ovf_next;
    always_comb begin
        logic [NUM_W:0]         q;
        logic [DEN_W+1:0]       twice_r;
        logic signed [NUM_W+1:0] sq;
        q       = {1'b0, fin.quo};
        twice_r = {fin.rem, 1'b0};
        if (twice_r >= {2'b00, fin.den})
            q = q + 1'b1;
        sq = fin.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        res_next = fin.res;
        ovf_next = fin.ovf;
        if (fin.is_div) begin
            if (sq > (NUM_W+2)'(64'sd2147483647)) begin
                res_next = 32'sh7FFF_FFFF;
                ovf_next = 1'b1;
            end else if (sq < -(NUM_W+2)'(64'sd2147483648)) begin
                res_next = 32'sh8000_0000;
                ovf_next = 1'b1;
            end else begin
                res_next = sq[DATA_W-1:0];
                ovf_next = 1'b0;
            end
        end
    end

    // whole part truncated toward zero: bias negatives before the shift
    logic signed [DATA_W-1:0] whole_full;
    assign whole_full = $signed(res_next + (res_next[DATA_W-1] ?
                         DATA_W'((1 << FRAC_BITS) - 1) : DATA_W'(0))) >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= fin.valid;
        end
        if (adv) begin
            res_reg   <= res_next;
            whole_reg <= whole_full[WHOLE_W-1:0];
            gt_reg    <= fin.gt;
            lt_reg    <= fin.lt;
            eq_reg    <= fin.eq;
            dz_reg    <= fin.dz;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_valid          = out_v_reg;
    assign m_result         = res_reg;
    assign m_whole_part     = whole_reg;
    assign m_a_greater      = gt_reg;
    assign m_a_less         = lt_reg;
    assign m_a_equal        = eq_reg;
    assign m_divide_by_zero = dz_reg;
    assign m_overflow       = ovf_reg;

`ifndef NO_ASSERTIONS
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_a_greater, m_a_less, m_a_equal}))
        else $error("compare flags not one-hot");
    a_dz_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_divide_by_zero && m_overflow))
        else $error("divide by zero with overflow");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result)))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready with empty output");
`endif
endmodule
